FILE: src/rgbfade_pkg.sv
// Shared types, codes and constants for the RGB LED fade and sleep controller.
`timescale 1ns / 1ps

package rgbfade_pkg;

  localparam int COLOR_W    = 8;
  localparam int DIVISOR_W  = 16;
  localparam int QUOT_W     = 8;
  localparam int DIVIDEND_W = COLOR_W + DIVISOR_W;
  localparam int CNT_W      = $clog2(QUOT_W);

  // Gamma is 255 - (2*x*x + 255) / 510, i.e. rounded x*x/255.
  localparam logic [DIVISOR_W-1:0] GAMMA_DIV = 16'd510;
  localparam logic [7:0]           COLOR_OFF = 8'd255;

  localparam logic [7:0]  SLEEP_LEVEL_RST = 8'd200;
  localparam logic [15:0] SLEEP_FADE_RST  = 16'd3000;

  // Opcodes
  localparam logic [2:0] OP_SET_NOW   = 3'd0;
  localparam logic [2:0] OP_SET_FADE  = 3'd1;
  localparam logic [2:0] OP_SLEEP_ON  = 3'd2;
  localparam logic [2:0] OP_SLEEP_OFF = 3'd3;
  localparam logic [2:0] OP_TICK      = 3'd4;

  // Config register indexes
  localparam logic CFG_SLEEP_LEVEL = 1'b0;
  localparam logic CFG_SLEEP_FADE  = 1'b1;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] fade_length;
    logic [31:0] now_time;
  } in_word_t;

  typedef struct packed {
    logic [7:0] pwm_red;
    logic [7:0] pwm_green;
    logic [7:0] pwm_blue;
    logic       still_fading;
    logic       asleep;
  } out_word_t;

  typedef logic [2:0][COLOR_W-1:0]    rgb_t;
  typedef logic [2:0][DIVIDEND_W-1:0] dividend3_t;

  typedef struct packed {
    logic                 start;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DT,
    S_MUL,
    S_FSTART,
    S_FWAIT,
    S_GSTART,
    S_GWAIT,
    S_OUT
  } state_t;

endpackage

FILE: src/rgbfade_div.sv
// Three-lane bit-serial restoring divider, one quotient bit per lane per cycle.
`timescale 1ns / 1ps

module rgbfade_div
  import rgbfade_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  div_req_t   req,
  input  dividend3_t dividend,
  output rgb_t       quot,
  output logic       done
);

  localparam int DEN_W = DIVISOR_W + QUOT_W - 1;

  logic [2:0][DIVIDEND_W-1:0] rem_r;
  logic [DEN_W-1:0]           den_r;
  rgb_t                       quot_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r;
  logic                       done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUOT_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) busy_r <= 1'b0;
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Remainder, shifted divisor and quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= dividend;
      den_r <= {req.divisor, {(QUOT_W-1){1'b0}}};
    end else if (busy_r) begin
      for (int i = 0; i < 3; i++) begin
        if (rem_r[i] >= DIVIDEND_W'(den_r)) begin
          rem_r[i]  <= rem_r[i] - DIVIDEND_W'(den_r);
          quot_r[i] <= {quot_r[i][QUOT_W-2:0], 1'b1};
        end else begin
          quot_r[i] <= {quot_r[i][QUOT_W-2:0], 1'b0};
        end
      end
      den_r <= den_r >> 1;
    end
  end

  assign quot = quot_r;
  assign done = done_r;

endmodule

FILE: src/rgb_led_fade_sleep_controller.sv
// Top level of the RGB LED fade and sleep controller.
`timescale 1ns / 1ps

// RGB backlight controller for common-anode LEDs (0 brightest, 255 off).
// Input channel (in_valid/in_ready/in_data) carries one command word: set
// colour now, set colour with fade, sleep on, sleep off, or a millisecond
// tick carrying now_time. Output channel (out_valid/out_ready/out_data)
// carries one word of gamma-corrected PWM duties plus fade/sleep flags each
// time the LEDs are driven; commands that do not drive the LEDs give none.
// cfg_we/cfg_index/cfg_wdata write sleep_level (0) and sleep_fade_length (1).
// Timing: one command at a time; a command with no output leaves the block idle.
// Set-now goes straight to gamma and out, a tick that ends a fade checks the
// elapsed time first, and a tick mid-fade also blends by dividing by the span.
// Both divisions use the three-lane bit-serial divider, the fade blend first
// and gamma after it, each pass on all three colours at once.
// in_ready is high only while idle. A finished word sits in the output
// register; the block returns to idle and takes new commands while it
// waits, and only stalls if a second word is ready before the first leaves.
// Reset (rst_n, synchronous) turns the LEDs off, clears the active colour,
// wakes the block, stops any fade and restores the config defaults.

module rgb_led_fade_sleep_controller
  import rgbfade_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  state_t state_r, state_nxt;

  // Config
  logic [7:0]  sleep_level_r;
  logic [15:0] sleep_fade_r;

  // Colour and fade state
  rgb_t        current_r, resume_r, from_r, to_r;
  logic        sleeping_r;
  logic        fade_active_r;
  logic [31:0] begin_r;
  logic [15:0] span_r;

  // Tick scratch
  logic [31:0]      now_r;
  logic [15:0]      dt_r;
  dividend3_t       prod_a_r, prod_b_r;

  logic      out_valid_r;
  out_word_t out_data_r;

  // Command decode
  logic        in_fire;
  logic        colour_op, fade_len_nz;
  logic        fade_go, set_now, tick_go;
  rgb_t        fade_tgt;
  logic [15:0] fade_len;

  // Tick timing
  logic [31:0] diff, dt32;
  logic        fade_ends;

  // Divider hookup
  div_req_t   div_req;
  dividend3_t div_dividend, fade_dividend, gamma_dividend;
  rgb_t       div_quot;
  logic       div_done;
  logic       out_slot, out_load;

  assign in_fire     = in_valid && in_ready;
  assign colour_op   = (in_data.opcode == OP_SET_NOW) || (in_data.opcode == OP_SET_FADE);
  assign fade_len_nz = (in_data.fade_length != 16'd0);

  always_comb begin
    fade_go = in_fire && (
      (colour_op && !sleeping_r && (in_data.opcode == OP_SET_FADE) && fade_len_nz) ||
      ((in_data.opcode == OP_SLEEP_ON) && !sleeping_r) ||
      ((in_data.opcode == OP_SLEEP_OFF) && sleeping_r));
    set_now = in_fire && colour_op && !sleeping_r &&
              !((in_data.opcode == OP_SET_FADE) && fade_len_nz);
    tick_go = in_fire && (in_data.opcode == OP_TICK) && fade_active_r;

    case (in_data.opcode)
      OP_SET_NOW, OP_SET_FADE: begin
        fade_tgt = {in_data.blue, in_data.green, in_data.red};
        fade_len = in_data.fade_length;
      end
      OP_SLEEP_ON: begin
        fade_tgt = {3{sleep_level_r}};
        fade_len = sleep_fade_r;
      end
      default: begin
        fade_tgt = resume_r;
        fade_len = sleep_fade_r;
      end
    endcase
  end

  // Elapsed time; a negative difference counts as zero
  assign diff      = now_r - begin_r;
  assign dt32      = diff[31] ? 32'd0 : diff;
  assign fade_ends = (dt32 >= {16'd0, span_r});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [7:0]  gx;
      logic [15:0] gsq;
      gx                = COLOR_OFF - current_r[i];
      gsq               = 16'(gx) * 16'(gx);
      fade_dividend[i]  = prod_a_r[i] + prod_b_r[i];
      gamma_dividend[i] = DIVIDEND_W'({gsq, 1'b0}) + DIVIDEND_W'(COLOR_OFF);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (set_now)      state_nxt = S_GSTART;
        else if (tick_go) state_nxt = S_DT;
      end
      S_DT:     state_nxt = fade_ends ? S_GSTART : S_MUL;
      S_MUL:    state_nxt = S_FSTART;
      S_FSTART: state_nxt = S_FWAIT;
      S_FWAIT:  if (div_done) state_nxt = S_GSTART;
      S_GSTART: state_nxt = S_GWAIT;
      S_GWAIT:  if (div_done) state_nxt = S_OUT;
      S_OUT:    if (out_slot) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  assign out_slot = !out_valid_r || out_ready;

  always_comb begin
    in_ready        = 1'b0;
    div_req.start   = 1'b0;
    div_req.divisor = GAMMA_DIV;
    div_dividend    = gamma_dividend;
    out_load        = 1'b0;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_FSTART: begin
        div_req.start   = 1'b1;
        div_req.divisor = span_r;
        div_dividend    = fade_dividend;
      end
      S_GSTART: div_req.start = 1'b1;
      S_OUT:    out_load = out_slot;
      default: ;
    endcase
  end

  rgbfade_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .quot     (div_quot),
    .done     (div_done)
  );

  // Control and colour state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      sleep_level_r <= SLEEP_LEVEL_RST;
      sleep_fade_r  <= SLEEP_FADE_RST;
      current_r     <= {3{COLOR_OFF}};
      resume_r      <= '0;
      from_r        <= {3{COLOR_OFF}};
      to_r          <= {3{COLOR_OFF}};
      sleeping_r    <= 1'b0;
      fade_active_r <= 1'b0;
      begin_r       <= '0;
      span_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          CFG_SLEEP_LEVEL: sleep_level_r <= cfg_wdata[7:0];
          CFG_SLEEP_FADE:  sleep_fade_r  <= cfg_wdata;
          default: ;
        endcase
      end

      if (in_fire && colour_op) resume_r <= {in_data.blue, in_data.green, in_data.red};
      if (in_fire && (in_data.opcode == OP_SLEEP_ON))  sleeping_r <= 1'b1;
      if (in_fire && (in_data.opcode == OP_SLEEP_OFF)) sleeping_r <= 1'b0;

      if (fade_go) begin
        from_r        <= current_r;
        to_r          <= fade_tgt;
        begin_r       <= in_data.now_time;
        span_r        <= fade_len;
        fade_active_r <= 1'b1;
      end

      if (set_now) begin
        current_r     <= {in_data.blue, in_data.green, in_data.red};
        fade_active_r <= 1'b0;
      end

      if ((state_r == S_DT) && fade_ends) begin
        current_r     <= to_r;
        fade_active_r <= 1'b0;
      end

      if ((state_r == S_FWAIT) && div_done) current_r <= div_quot;

      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (tick_go) now_r <= in_data.now_time;
    if (state_r == S_DT) dt_r <= dt32[15:0];
    if (state_r == S_MUL) begin
      for (int i = 0; i < 3; i++) begin
        prod_a_r[i] <= DIVIDEND_W'(from_r[i]) * DIVIDEND_W'(span_r - dt_r);
        prod_b_r[i] <= DIVIDEND_W'(to_r[i]) * DIVIDEND_W'(dt_r);
      end
    end
    if (out_load) begin
      out_data_r.pwm_red      <= COLOR_OFF - div_quot[0];
      out_data_r.pwm_green    <= COLOR_OFF - div_quot[1];
      out_data_r.pwm_blue     <= COLOR_OFF - div_quot[2];
      out_data_r.still_fading <= fade_active_r;
      out_data_r.asleep       <= sleeping_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Divider only reports done while the sequencer waits on it
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_FWAIT || state_r == S_GWAIT))
    else $error("divider done outside a wait state");

  // Blend division never runs with a zero span
  a_span_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FSTART) |-> (span_r != 16'd0) && fade_active_r)
    else $error("fade division with zero span or no fade");

  // Colour commands while asleep never drive the LEDs
  a_sleep_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && colour_op && sleeping_r) |=> (state_r == S_IDLE))
    else $error("colour command drove LEDs while asleep");

  // A mid-fade tick leaves the fade running
  a_mid_fade: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DT && !fade_ends) |=> fade_active_r)
    else $error("fade stopped on an interpolating tick");

endmodule

FILE: dv/rgb_led_fade_sleep_controller_tb.sv
// Self-checking testbench for the RGB LED fade and sleep controller.
`timescale 1ns / 1ps

module rgb_led_fade_sleep_controller_tb;
  import rgbfade_pkg::*;

  // One colour triple, [0] red, [1] green, [2] blue.
  typedef logic [2:0][7:0] shade_t;

  // Tracks the LED state from accepted command words and holds the PWM words
  // that the block owes us, oldest first.
  class led_state_tracker;
    logic [7:0]  dim_level;
    logic [15:0] nap_span;
    shade_t      lit, wanted, fade_src, fade_dst;
    bit          dozing, fading;
    logic [31:0] fade_t0;
    logic [15:0] fade_len;
    out_word_t   pwm_due_q[$];
    int unsigned mismatches;

    function new();
      dim_level  = SLEEP_LEVEL_RST;
      nap_span   = SLEEP_FADE_RST;
      lit        = {3{COLOR_OFF}};
      wanted     = '0;
      fade_src   = {3{COLOR_OFF}};
      fade_dst   = {3{COLOR_OFF}};
      dozing     = 1'b0;
      fading     = 1'b0;
      fade_t0    = '0;
      fade_len   = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] data);
      if (idx == CFG_SLEEP_LEVEL) dim_level = data[7:0];
      else nap_span = data;
    endfunction

    // 255 - round((255-v)^2 / 255)
    function logic [7:0] gamma_duty(logic [7:0] v);
      int unsigned x;
      x = 255 - v;
      return 8'(255 - (2 * x * x + 255) / 510);
    endfunction

    function void drive_leds();
      out_word_t w;
      w.pwm_red      = gamma_duty(lit[0]);
      w.pwm_green    = gamma_duty(lit[1]);
      w.pwm_blue     = gamma_duty(lit[2]);
      w.still_fading = fading;
      w.asleep       = dozing;
      pwm_due_q.push_back(w);
    endfunction

    function void start_fade(shade_t target, logic [31:0] now, logic [15:0] span);
      fade_src = lit;
      fade_dst = target;
      fade_t0  = now;
      fade_len = span;
      fading   = 1'b1;
    endfunction

    function void advance_fade(logic [31:0] now);
      logic [31:0] dt;
      int unsigned mix;
      dt = now - fade_t0;
      if (dt[31]) dt = '0;  // clock behind the fade start counts as no time
      if (dt >= 32'(fade_len)) begin
        lit    = fade_dst;
        fading = 1'b0;
      end else begin
        for (int c = 0; c < 3; c++) begin
          mix    = fade_src[c] * (fade_len - dt) + fade_dst[c] * dt;
          lit[c] = 8'(mix / fade_len);
        end
      end
      drive_leds();
    endfunction

    function void note_command(in_word_t w);
      shade_t req;
      req = {w.blue, w.green, w.red};
      case (w.opcode)
        OP_SET_NOW, OP_SET_FADE: begin
          wanted = req;
          if (dozing) return;
          if (w.opcode == OP_SET_FADE && w.fade_length != 0) begin
            start_fade(req, w.now_time, w.fade_length);
            return;
          end
          lit    = req;
          fading = 1'b0;
          drive_leds();
        end
        OP_SLEEP_ON: begin
          if (!dozing) begin
            dozing = 1'b1;
            start_fade({3{dim_level}}, w.now_time, nap_span);
          end
        end
        OP_SLEEP_OFF: begin
          if (dozing) begin
            dozing = 1'b0;
            start_fade(wanted, w.now_time, nap_span);
          end
        end
        OP_TICK: begin
          if (fading) advance_fade(w.now_time);
        end
        default: ;
      endcase
    endfunction

    function string show(out_word_t w);
      return $sformatf("r=%02h g=%02h b=%02h fading=%0b asleep=%0b",
                       w.pwm_red, w.pwm_green, w.pwm_blue, w.still_fading, w.asleep);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at %0t: %s", $time, msg);
    endfunction

    function void check_pwm(out_word_t got);
      out_word_t want;
      if (pwm_due_q.size() == 0) begin
        flag({"unexpected word ", show(got)});
        return;
      end
      want = pwm_due_q.pop_front();
      if (got.pwm_red !== want.pwm_red || got.pwm_green !== want.pwm_green ||
          got.pwm_blue !== want.pwm_blue || got.still_fading !== want.still_fading ||
          got.asleep !== want.asleep)
        flag({"expected ", show(want), ", got ", show(got)});
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  led_state_tracker sb;
  logic [31:0]      clock_ms;     // running millisecond clock for the random part
  int unsigned      real_items;   // accepted words with a defined opcode
  int unsigned      tx_items;
  bit               tx_calm;      // sender in a no-gap stretch

  rgb_led_fade_sleep_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #(10_000_000);
    $display("status: fail");
    $finish;
  end

  // Both handshakes are sampled here, at the rising edge, with the values
  // that the block saw. A word accepted on this edge cannot produce its
  // result on the same edge, so the order of the two calls does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_pwm(out_data);
      if (in_valid && in_ready) sb.note_command(in_data);
    end
  end

  // Result side: a random stall before each word, with calm stretches, and
  // two long hold-offs so that a second result backs up behind the output
  // register and in_ready drops while the sender keeps offering words.
  initial begin : result_sink
    int unsigned hold;
    int unsigned taken;
    bit calm;
    out_ready = 1'b0;
    taken = 0;
    calm = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if (taken == 40 || taken == 500) hold = 600;
      else hold = calm ? 0 : $urandom_range(0, 18);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
      @(negedge clk);
    end
  end

  function automatic in_word_t command_word(logic [2:0] op, logic [23:0] rgb,
                                            logic [15:0] len, logic [31:0] now);
    return {op, rgb, len, now};
  endfunction

  // Offers one word after a random gap; returns at the falling edge after
  // the word is taken, with in_valid still high.
  task automatic send_word(in_word_t w);
    int unsigned gap;
    if (tx_items % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    tx_items++;
    gap = tx_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (w.opcode <= OP_TICK) real_items++;
    @(negedge clk);
  endtask

  task automatic tick_after(int unsigned step);
    clock_ms += step;
    send_word(command_word(OP_TICK, 24'($urandom), 16'($urandom), clock_ms));
  endtask

  // Stops offering words, waits for every owed result, then lets the clock run
  // on with nothing offered.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pwm_due_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned quota;
    int unsigned pick;
    logic [15:0] len;
    logic [7:0]  lvl;
    logic [15:0] span;
    sb = new();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_SLEEP_LEVEL;
    cfg_wdata  = '0;
    clock_ms   = '0;
    real_items = 0;
    tx_items   = 0;
    tx_calm    = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, reset config (dim 200, 3000 ms).
    send_word(command_word(OP_TICK,     24'h123456, 16'h0000, 32'h0000_0000)); // no fade
    send_word(command_word(OP_SET_NOW,  24'h000000, 16'hFFFF, 32'h0000_0000)); // full on
    send_word(command_word(OP_SET_NOW,  24'hFFFFFF, 16'h0000, 32'hFFFF_FFFF)); // off
    send_word(command_word(OP_SET_NOW,  24'h55AA0F, 16'h1234, 32'h0000_0010));
    send_word(command_word(OP_SET_FADE, 24'hF033CC, 16'h0000, 32'h0000_0020)); // acts as set
    send_word(command_word(OP_SET_FADE, 24'h0080FF, 16'd1000, 32'd1000));
    send_word(command_word(OP_TICK,     24'h000000, 16'h0000, 32'd500));  // clock behind
    send_word(command_word(OP_TICK,     24'hFFFFFF, 16'hFFFF, 32'd1250));
    send_word(command_word(OP_TICK,     24'h000000, 16'h0000, 32'd1999));
    send_word(command_word(OP_TICK,     24'h000000, 16'h0000, 32'd2000)); // fade done
    send_word(command_word(OP_TICK,     24'h000000, 16'h0000, 32'd3000)); // nothing running
    send_word(command_word(OP_SET_FADE, 24'hFF0080, 16'hFFFF, 32'hFFFF_FF00));
    send_word(command_word(OP_TICK,     24'h000000, 16'h0000, 32'h0000_1000)); // across wrap
    send_word(command_word(OP_SLEEP_OFF, 24'h000000, 16'h0000, 32'h0000_2000)); // awake
    send_word(command_word(OP_SLEEP_ON, 24'h000000, 16'h0000, 32'h0001_0000)); // cuts fade
    send_word(command_word(OP_SLEEP_ON, 24'h000000, 16'h0000, 32'h0001_0100)); // asleep
    send_word(command_word(OP_SET_NOW,  24'h0A141E, 16'h0000, 32'h0001_0200)); // only kept
    send_word(command_word(OP_SET_FADE, 24'h28323C, 16'd7,    32'h0001_0300)); // only kept
    send_word(command_word(OP_TICK,     24'h000000, 16'h0000, 32'h0001_05DC));
    send_word(command_word(OP_TICK,     24'h000000, 16'h0000, 32'h0001_0BB8)); // dim white
    send_word(command_word(OP_SLEEP_OFF, 24'h000000, 16'h0000, 32'h0002_0000));
    send_word(command_word(OP_TICK,     24'h000000, 16'h0000, 32'h8002_0000)); // dt < 0
    send_word(command_word(OP_TICK,     24'h000000, 16'h0000, 32'h8001_FFFF)); // dt max
    for (int op = 5; op < 8; op++)  // unused opcodes are dropped
      send_word(command_word(3'(op), 24'($urandom), 16'($urandom), $urandom));

    // Random part in five config phases: reset values, both extremes, a zero
    // sleep fade (next tick ends it) and a random setting.
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        settle();
        case (ph)
          1: begin
            lvl  = 8'd0;
            span = 16'd1;
          end
          2: begin
            lvl  = 8'd255;
            span = 16'hFFFF;
          end
          3: begin
            lvl  = 8'($urandom);
            span = 16'd0;
          end
          default: begin
            lvl  = 8'($urandom);
            span = 16'($urandom_range(1, 4000));
          end
        endcase
        write_reg(CFG_SLEEP_LEVEL, {8'($urandom), lvl});
        write_reg(CFG_SLEEP_FADE, span);
      end
      clock_ms = $urandom;
      quota = real_items + 280;
      while (real_items < quota) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          // fade to a random colour, then sample it on the way
          len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
          send_word(command_word(OP_SET_FADE, 24'($urandom), len, clock_ms));
          repeat ($urandom_range(1, 6)) tick_after($urandom_range(0, len / 3 + 2));
        end else if (pick < 55) begin
          // sleep, maybe pick a new colour while asleep, then wake
          send_word(command_word(OP_SLEEP_ON, 24'($urandom), 16'($urandom), clock_ms));
          repeat ($urandom_range(0, 4)) tick_after($urandom_range(0, sb.nap_span / 3 + 2));
          if ($urandom_range(0, 1))
            send_word(command_word($urandom_range(0, 1) ? OP_SET_FADE : OP_SET_NOW,
                                   24'($urandom), 16'($urandom), clock_ms));
          send_word(command_word(OP_SLEEP_OFF, 24'($urandom), 16'($urandom), clock_ms));
          repeat ($urandom_range(0, 4)) tick_after($urandom_range(0, sb.nap_span / 3 + 2));
        end else if (pick < 70) begin
          send_word(command_word(OP_SET_NOW, 24'($urandom), 16'($urandom), clock_ms));
        end else if (pick < 85) begin
          // lone tick, sometimes with the clock stepping backwards
          if ($urandom_range(0, 3) == 0)
            send_word(command_word(OP_TICK, 24'($urandom), 16'($urandom),
                                   clock_ms - $urandom_range(1, 5000)));
          else
            tick_after($urandom_range(0, 3000));
        end else begin
          // noise: any opcode, any field
          send_word(command_word(3'($urandom), 24'($urandom), 16'($urandom), $urandom));
        end
      end
    end

    settle();
    if (sb.mismatches == 0 && sb.pwm_due_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
